// ===== sv/lcdseq_pkg.sv =====
package lcdseq_pkg;

    // request operation codes
    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_CMD    = 2'd1,
        OP_DATA   = 2'd2,
        OP_CURSOR = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE_PULSE   = 2'd0,
        CFG_COMMAND_SETTLE = 2'd1,
        CFG_CHAR_SETTLE    = 2'd2
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PULSE_W    = 10;
    localparam int HOLD_W     = 16;

    localparam logic [PULSE_W-1:0] RST_ENABLE_PULSE   = 10'd40;
    localparam logic [HOLD_W-1:0]  RST_COMMAND_SETTLE = 16'd2000;
    localparam logic [HOLD_W-1:0]  RST_CHAR_SETTLE    = 16'd40;

    // phase counts and index width
    localparam int PHASE_IDX_W = 5;
    localparam int INIT_PHASES = 26;
    localparam int BYTE_PHASES = 4;

    // fixed wake-up timing in microseconds
    localparam logic [HOLD_W-1:0] INIT_IDLE_US   = 16'd20000;
    localparam logic [HOLD_W-1:0] WAKE_PULSE_US  = 16'd5000;
    localparam logic [HOLD_W-1:0] WAKE_FIRST_US  = 16'd5000;
    localparam logic [HOLD_W-1:0] WAKE_SECOND_US = 16'd150;
    localparam logic [HOLD_W-1:0] FINAL_WAIT_US  = 16'd2000;

    localparam logic [3:0] WAKE_NIBBLE      = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIBBLE  = 4'h2;

    // init set-up commands
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;

    // cursor address bases
    localparam logic [7:0] DDRAM_LINE1 = 8'h80;
    localparam logic [7:0] DDRAM_LINE2 = 8'hC0;

    // first and last init phases that belong to the set-up commands
    localparam int INIT_CMD_FIRST = 9;
    localparam int INIT_CMD_LAST  = 24;

    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] byte_value;
    } t_job;

    typedef struct packed {
        logic [PULSE_W-1:0] enable_pulse_us;
        logic [HOLD_W-1:0]  command_settle_us;
        logic [HOLD_W-1:0]  char_settle_us;
    } t_cfg;

    typedef struct packed {
        logic              reg_select;
        logic [3:0]        data_nibble;
        logic              enable;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } t_phase;

    // one of the four phases of a byte, last flag left clear
    function automatic t_phase byte_phase(
        input logic              rs,
        input logic [7:0]        b,
        input logic [1:0]        sub,
        input logic [HOLD_W-1:0] pulse,
        input logic [HOLD_W-1:0] settle
    );
        t_phase p;
        p.reg_select = rs;
        p.last       = 1'b0;
        case (sub)
            2'd0: begin
                p.data_nibble = b[7:4];
                p.enable      = 1'b1;
                p.hold_us     = pulse;
            end
            2'd1: begin
                p.data_nibble = b[7:4];
                p.enable      = 1'b0;
                p.hold_us     = '0;
            end
            2'd2: begin
                p.data_nibble = b[3:0];
                p.enable      = 1'b1;
                p.hold_us     = pulse;
            end
            default: begin
                p.data_nibble = b[3:0];
                p.enable      = 1'b0;
                p.hold_us     = settle;
            end
        endcase
        return p;
    endfunction

    // phase of the init run at a given index, last flag left clear
    function automatic t_phase init_phase(
        input logic [PHASE_IDX_W-1:0] idx,
        input logic [HOLD_W-1:0]      pulse,
        input logic [HOLD_W-1:0]      settle
    );
        t_phase                 p;
        logic [PHASE_IDX_W-1:0] off;
        logic [7:0]             cmd;
        off = idx - PHASE_IDX_W'(INIT_CMD_FIRST);
        case (off[3:2])
            2'd0:    cmd = CMD_FUNCTION_SET;
            2'd1:    cmd = CMD_DISPLAY_ON;
            2'd2:    cmd = CMD_ENTRY_MODE;
            default: cmd = CMD_CLEAR;
        endcase
        p = byte_phase(1'b0, cmd, off[1:0], pulse, settle);
        if (idx == '0) begin
            // power-up idle
            p.data_nibble = 4'h0;
            p.enable      = 1'b0;
            p.hold_us     = INIT_IDLE_US;
        end else if (idx < PHASE_IDX_W'(INIT_CMD_FIRST)) begin
            // wake-up nibbles, odd indexes strobe high
            p.data_nibble = (idx <= 5'd6) ? WAKE_NIBBLE : FOUR_BIT_NIBBLE;
            p.enable      = idx[0];
            if (idx[0]) begin
                p.hold_us = WAKE_PULSE_US;
            end else if (idx == 5'd2) begin
                p.hold_us = WAKE_FIRST_US;
            end else if (idx == 5'd4) begin
                p.hold_us = WAKE_SECOND_US;
            end else begin
                p.hold_us = '0;
            end
        end else if (idx > PHASE_IDX_W'(INIT_CMD_LAST)) begin
            // closing wait with clear-display low nibble still driven
            p.data_nibble = CMD_CLEAR[3:0];
            p.enable      = 1'b0;
            p.hold_us     = FINAL_WAIT_US;
        end
        p.reg_select = 1'b0;
        p.last       = 1'b0;
        return p;
    endfunction

endpackage

// ===== sv/lcdseq_req_if.sv =====
interface lcdseq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] byte_value;
    logic [1:0] row;
    logic [5:0] col;

    modport source (output valid, operation, byte_value, row, col, input ready);
    modport sink (input valid, operation, byte_value, row, col, output ready);
endinterface

// ===== sv/lcdseq_phase_if.sv =====
interface lcdseq_phase_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [3:0]  data_nibble;
    logic        enable;
    logic [15:0] hold_us;
    logic        last;

    modport source (output valid, reg_select, data_nibble, enable, hold_us, last,
                    input ready);
    modport sink (input valid, reg_select, data_nibble, enable, hold_us, last,
                  output ready);
endinterface

// ===== sv/lcdseq_front.sv =====
module lcdseq_front (
    lcdseq_req_if.sink       i_req,
    input  logic             i_queue_full,
    output logic             o_push,
    output lcdseq_pkg::t_job o_job
);

    logic [7:0] cursor_addr;

    // cursor address from row and column, wrapping at 8 bits
    always_comb begin
        cursor_addr = ((i_req.row == 2'd1) ? lcdseq_pkg::DDRAM_LINE1
                                           : lcdseq_pkg::DDRAM_LINE2)
                      + {2'b00, i_req.col} - 8'd1;
    end

    // classify the request into a job for the back end
    always_comb begin
        o_job.is_init    = 1'b0;
        o_job.reg_select = 1'b0;
        o_job.byte_value = i_req.byte_value;
        case (lcdseq_pkg::t_op'(i_req.operation))
            lcdseq_pkg::OP_INIT: begin
                o_job.is_init = 1'b1;
            end
            lcdseq_pkg::OP_CMD: begin
                o_job.reg_select = 1'b0;
            end
            lcdseq_pkg::OP_DATA: begin
                o_job.reg_select = 1'b1;
            end
            lcdseq_pkg::OP_CURSOR: begin
                o_job.byte_value = cursor_addr;
            end
            default: begin
                o_job.is_init = 1'b0;
            end
        endcase
    end

    // handshake
    assign i_req.ready = !i_queue_full;
    assign o_push      = i_req.valid && !i_queue_full;

endmodule

// ===== sv/lcdseq_queue.sv =====
module lcdseq_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lcdseq_pkg::t_job i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output lcdseq_pkg::t_job o_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdseq_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/lcdseq_back.sv =====
module lcdseq_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  lcdseq_pkg::t_job i_job,
    input  lcdseq_pkg::t_cfg i_cfg,
    output logic             o_pop,
    lcdseq_phase_if.source   o_phase
);

    localparam int IW = lcdseq_pkg::PHASE_IDX_W;
    localparam int HW = lcdseq_pkg::HOLD_W;

    logic [IW-1:0]      r_idx, n_idx;
    logic               r_valid, n_valid;
    lcdseq_pkg::t_phase r_out, n_out;
    logic               advance, is_last;
    logic [HW-1:0]      pulse, settle;
    lcdseq_pkg::t_phase cur;

    assign pulse  = {{(HW - lcdseq_pkg::PULSE_W){1'b0}}, i_cfg.enable_pulse_us};
    assign settle = i_job.reg_select ? i_cfg.char_settle_us : i_cfg.command_settle_us;

    // current phase of the head job
    always_comb begin
        if (i_job.is_init) begin
            cur     = lcdseq_pkg::init_phase(r_idx, pulse, i_cfg.command_settle_us);
            is_last = (r_idx == IW'(lcdseq_pkg::INIT_PHASES - 1));
        end else begin
            cur     = lcdseq_pkg::byte_phase(i_job.reg_select, i_job.byte_value,
                                             r_idx[1:0], pulse, settle);
            is_last = (r_idx == IW'(lcdseq_pkg::BYTE_PHASES - 1));
        end
        cur.last = is_last;
    end

    // output register loads whenever a job is waiting and it is free or being drained
    assign advance = i_job_valid && (!r_valid || o_phase.ready);
    assign o_pop   = advance && is_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && !o_phase.ready;
        n_out   = r_out;
        if (advance) begin
            n_valid = 1'b1;
            n_out   = cur;
            n_idx   = is_last ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // drive the phase channel
    assign o_phase.valid       = r_valid;
    assign o_phase.reg_select  = r_out.reg_select;
    assign o_phase.data_nibble = r_out.data_nibble;
    assign o_phase.enable      = r_out.enable;
    assign o_phase.hold_us     = r_out.hold_us;
    assign o_phase.last        = r_out.last;

endmodule

// ===== sv/char_lcd_nibble_bus_sequencer.sv =====
// Expands each request into 4-bit character-LCD bus phases (RS, D4..D7, E, hold time),
// one phase per clock on the output channel while the sink is ready. Command,
// character and set-cursor requests produce 4 phases each; init produces 26
// phases. The phase generator in the back end emits one phase per cycle while
// the sink keeps ready high and a job is waiting. A small job queue in front of
// it keeps accepting requests while earlier ones are still being played out,
// so requests are taken back to back as long as the queue has room.
// Configuration: index 0 enable pulse (10 bits, reset 40 us), index 1 command settle
// (reset 2000 us), index 2 character settle (reset 40 us); other indexes are ignored.
module char_lcd_nibble_bus_sequencer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcdseq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcdseq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lcdseq_req_if.sink                        i_req,
    lcdseq_phase_if.source                    o_phase
);

    lcdseq_pkg::t_cfg r_cfg;
    lcdseq_pkg::t_job front_job, head_job;
    logic             push, pop, q_full, q_empty;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_pulse_us   <= lcdseq_pkg::RST_ENABLE_PULSE;
            r_cfg.command_settle_us <= lcdseq_pkg::RST_COMMAND_SETTLE;
            r_cfg.char_settle_us    <= lcdseq_pkg::RST_CHAR_SETTLE;
        end else if (i_cfg_we) begin
            case (lcdseq_pkg::t_cfg_idx'(i_cfg_idx))
                lcdseq_pkg::CFG_ENABLE_PULSE: begin
                    r_cfg.enable_pulse_us <= i_cfg_data[lcdseq_pkg::PULSE_W-1:0];
                end
                lcdseq_pkg::CFG_COMMAND_SETTLE: begin
                    r_cfg.command_settle_us <= i_cfg_data;
                end
                lcdseq_pkg::CFG_CHAR_SETTLE: begin
                    r_cfg.char_settle_us <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // request classification
    lcdseq_front u_front (
        .i_req        (i_req),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    // job queue between front and back
    lcdseq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    // phase generation
    lcdseq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (head_job),
        .i_cfg       (r_cfg),
        .o_pop       (pop),
        .o_phase     (o_phase)
    );

endmodule

// ===== sim/lcd_phase_checker.sv =====
module lcd_phase_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcdseq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lcdseq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lcdseq_req_if                             req_mon,
    lcdseq_phase_if                           phase_mon,
    output int                                o_failures,
    output int                                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = lcdseq_pkg::PULSE_W;
    localparam int HW = lcdseq_pkg::HOLD_W;

    // power-on register values
    localparam logic [PW-1:0] PULSE_AT_RESET      = 10'd40;
    localparam logic [HW-1:0] CMD_SETTLE_AT_RESET = 16'd2000;
    localparam logic [HW-1:0] CHR_SETTLE_AT_RESET = 16'd40;

    // wake-up sequence timing and pin values
    localparam logic [HW-1:0] POWER_UP_US    = 16'd20000;
    localparam logic [HW-1:0] WAKE_STROBE_US = 16'd5000;
    localparam logic [HW-1:0] WAKE_GAP1_US   = 16'd5000;
    localparam logic [HW-1:0] WAKE_GAP2_US   = 16'd150;
    localparam logic [HW-1:0] CLOSING_US     = 16'd2000;
    localparam logic [3:0]    NIB_WAKE       = 4'h3;
    localparam logic [3:0]    NIB_FOUR_BIT   = 4'h2;
    localparam logic [3:0]    NIB_CLOSING    = 4'h1;

    // set-up commands and cursor address bases
    localparam logic [7:0] SETUP_FUNCTION = 8'h28;
    localparam logic [7:0] SETUP_DISPLAY  = 8'h0C;
    localparam logic [7:0] SETUP_ENTRY    = 8'h06;
    localparam logic [7:0] SETUP_CLEAR    = 8'h01;
    localparam logic [7:0] LINE1_BASE     = 8'h80;
    localparam logic [7:0] LINE2_BASE     = 8'hC0;

    logic [PW-1:0]      pulse_us;
    logic [HW-1:0]      cmd_settle_us;
    logic [HW-1:0]      chr_settle_us;
    lcdseq_pkg::t_phase expected_phases[$];
    int                 failures = 0;

    function automatic lcdseq_pkg::t_phase mk_phase(input logic rs, input logic [3:0] nib,
                                                    input logic en,
                                                    input logic [HW-1:0] hold,
                                                    input logic last_flag);
        lcdseq_pkg::t_phase p;
        p.reg_select  = rs;
        p.data_nibble = nib;
        p.enable      = en;
        p.hold_us     = hold;
        p.last        = last_flag;
        return p;
    endfunction

    // one byte: high nibble strobe, low nibble strobe, settle on the last phase
    task automatic queue_byte(input logic rs, input logic [7:0] b,
                              input logic [HW-1:0] settle, input logic last_flag);
        logic [HW-1:0] pulse16;
        pulse16 = HW'(pulse_us);
        expected_phases.push_back(mk_phase(rs, b[7:4], 1'b1, pulse16, 1'b0));
        expected_phases.push_back(mk_phase(rs, b[7:4], 1'b0, '0, 1'b0));
        expected_phases.push_back(mk_phase(rs, b[3:0], 1'b1, pulse16, 1'b0));
        expected_phases.push_back(mk_phase(rs, b[3:0], 1'b0, settle, last_flag));
    endtask

    // expand one request into the bus phases it should produce
    task automatic expand_request(input lcdseq_pkg::t_op op, input logic [7:0] b,
                                  input logic [1:0] row, input logic [5:0] col);
        logic [7:0] addr;
        case (op)
            lcdseq_pkg::OP_INIT: begin
                expected_phases.push_back(mk_phase(1'b0, 4'h0, 1'b0, POWER_UP_US, 1'b0));
                expected_phases.push_back(mk_phase(1'b0, NIB_WAKE, 1'b1, WAKE_STROBE_US,
                                                   1'b0));
                expected_phases.push_back(mk_phase(1'b0, NIB_WAKE, 1'b0, WAKE_GAP1_US, 1'b0));
                expected_phases.push_back(mk_phase(1'b0, NIB_WAKE, 1'b1, WAKE_STROBE_US,
                                                   1'b0));
                expected_phases.push_back(mk_phase(1'b0, NIB_WAKE, 1'b0, WAKE_GAP2_US, 1'b0));
                expected_phases.push_back(mk_phase(1'b0, NIB_WAKE, 1'b1, WAKE_STROBE_US,
                                                   1'b0));
                expected_phases.push_back(mk_phase(1'b0, NIB_WAKE, 1'b0, '0, 1'b0));
                expected_phases.push_back(mk_phase(1'b0, NIB_FOUR_BIT, 1'b1, WAKE_STROBE_US,
                                                   1'b0));
                expected_phases.push_back(mk_phase(1'b0, NIB_FOUR_BIT, 1'b0, '0, 1'b0));
                queue_byte(1'b0, SETUP_FUNCTION, cmd_settle_us, 1'b0);
                queue_byte(1'b0, SETUP_DISPLAY, cmd_settle_us, 1'b0);
                queue_byte(1'b0, SETUP_ENTRY, cmd_settle_us, 1'b0);
                queue_byte(1'b0, SETUP_CLEAR, cmd_settle_us, 1'b0);
                expected_phases.push_back(mk_phase(1'b0, NIB_CLOSING, 1'b0, CLOSING_US, 1'b1));
            end
            lcdseq_pkg::OP_CMD: begin
                queue_byte(1'b0, b, cmd_settle_us, 1'b1);
            end
            lcdseq_pkg::OP_DATA: begin
                queue_byte(1'b1, b, chr_settle_us, 1'b1);
            end
            default: begin
                // row 1 is line 1, anything else line 2; address wraps at 8 bits
                addr = ((row == 2'd1) ? LINE1_BASE : LINE2_BASE) + {2'b00, col} - 8'd1;
                queue_byte(1'b0, addr, cmd_settle_us, 1'b1);
            end
        endcase
    endtask

    // track registers, predict on each request, compare each phase
    always @(posedge i_clk) begin
        lcdseq_pkg::t_phase want;
        lcdseq_pkg::t_phase got;
        if (!i_rst_n) begin
            pulse_us      = PULSE_AT_RESET;
            cmd_settle_us = CMD_SETTLE_AT_RESET;
            chr_settle_us = CHR_SETTLE_AT_RESET;
            expected_phases.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lcdseq_pkg::CFG_ENABLE_PULSE:   pulse_us      = i_cfg_data[PW-1:0];
                    lcdseq_pkg::CFG_COMMAND_SETTLE: cmd_settle_us = i_cfg_data;
                    lcdseq_pkg::CFG_CHAR_SETTLE:    chr_settle_us = i_cfg_data;
                    default: ;
                endcase
            end
            if (req_mon.valid && req_mon.ready) begin
                expand_request(lcdseq_pkg::t_op'(req_mon.operation), req_mon.byte_value,
                               req_mon.row, req_mon.col);
            end
            if (phase_mon.valid && phase_mon.ready) begin
                got = mk_phase(phase_mon.reg_select, phase_mon.data_nibble,
                               phase_mon.enable, phase_mon.hold_us, phase_mon.last);
                if (expected_phases.size() == 0) begin
                    failures++;
                    $display({"%0t: unexpected phase, expected none, ",
                              "actual rs=%0b nib=%h en=%0b hold=%0d last=%0b"},
                             $time, got.reg_select, got.data_nibble, got.enable,
                             got.hold_us, got.last);
                end else begin
                    want = expected_phases.pop_front();
                    if (got.reg_select !== want.reg_select ||
                        got.data_nibble !== want.data_nibble ||
                        got.enable !== want.enable ||
                        got.hold_us !== want.hold_us ||
                        got.last !== want.last) begin
                        failures++;
                        $display({"%0t: phase differs, ",
                                  "expected rs=%0b nib=%h en=%0b hold=%0d last=%0b, ",
                                  "actual rs=%0b nib=%h en=%0b hold=%0d last=%0b"},
                                 $time, want.reg_select, want.data_nibble, want.enable,
                                 want.hold_us, want.last, got.reg_select, got.data_nibble,
                                 got.enable, got.hold_us, got.last);
                    end
                end
            end
        end
        o_pending  <= expected_phases.size();
        o_failures <= failures;
    end

endmodule

// ===== sim/char_lcd_nibble_bus_sequencer_tb.sv =====
module char_lcd_nibble_bus_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW = lcdseq_pkg::CFG_IDX_W;
    localparam int DW = lcdseq_pkg::CFG_DATA_W;

    localparam logic [IW-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int IDLE_PCT        = 13;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int SEGMENT_ITEMS   = 40;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [IW-1:0] i_cfg_idx;
    logic [DW-1:0] i_cfg_data;

    bit quiet;
    bit hold_off_req;
    bit hold_off_done;
    int failures;
    int pending;
    int stall_cycles = 0;

    lcdseq_req_if   req_if ();
    lcdseq_phase_if phase_if ();

    char_lcd_nibble_bus_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_phase    (phase_if)
    );

    lcd_phase_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req_mon    (req_if),
        .phase_mon  (phase_if),
        .o_failures (failures),
        .o_pending  (pending)
    );

    always #5 i_clk = ~i_clk;

    // offer one request, with random idle cycles ahead of it
    task automatic send_request(input lcdseq_pkg::t_op op, input logic [7:0] b,
                                input logic [1:0] row, input logic [5:0] col);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid      <= 1'b1;
        req_if.operation  <= op;
        req_if.byte_value <= b;
        req_if.row        <= row;
        req_if.col        <= col;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // stop offering and wait until every predicted phase has come out
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write all registers back to back, plus one ignored index
    task automatic write_settings(input logic [15:0] pulse, input logic [15:0] cmd_settle,
                                  input logic [15:0] chr_settle);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= lcdseq_pkg::CFG_ENABLE_PULSE;
        i_cfg_data <= pulse;
        @(posedge i_clk);
        i_cfg_idx  <= lcdseq_pkg::CFG_COMMAND_SETTLE;
        i_cfg_data <= cmd_settle;
        @(posedge i_clk);
        i_cfg_idx  <= lcdseq_pkg::CFG_CHAR_SETTLE;
        i_cfg_data <= chr_settle;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_UNUSED_IDX;
        i_cfg_data <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random mix, init kept rare since it is long
    task automatic random_requests(input int n);
        lcdseq_pkg::t_op op;
        int              r;
        repeat (n) begin
            r = $urandom_range(9);
            if (r == 0) begin
                op = lcdseq_pkg::OP_INIT;
            end else if (r < 4) begin
                op = lcdseq_pkg::OP_CMD;
            end else if (r < 7) begin
                op = lcdseq_pkg::OP_DATA;
            end else begin
                op = lcdseq_pkg::OP_CURSOR;
            end
            send_request(op, 8'($urandom_range(255)), 2'($urandom_range(3)),
                         6'($urandom_range(63)));
        end
    endtask

    // request stimulus and verdict
    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= lcdseq_pkg::CFG_ENABLE_PULSE;
        i_cfg_data        <= '0;
        req_if.valid      <= 1'b0;
        req_if.operation  <= lcdseq_pkg::OP_INIT;
        req_if.byte_value <= '0;
        req_if.row        <= '0;
        req_if.col        <= '0;
        quiet             = 1'b0;
        hold_off_req      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, byte extremes, cursor corners and wraps
        send_request(lcdseq_pkg::OP_INIT, 8'h00, 2'd1, 6'd1);
        send_request(lcdseq_pkg::OP_CMD, 8'h00, 2'd0, 6'd0);
        send_request(lcdseq_pkg::OP_CMD, 8'hFF, 2'd3, 6'd63);
        send_request(lcdseq_pkg::OP_DATA, 8'h00, 2'd0, 6'd0);
        send_request(lcdseq_pkg::OP_DATA, 8'hFF, 2'd3, 6'd63);
        send_request(lcdseq_pkg::OP_DATA, 8'h5A, 2'd2, 6'd21);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd1, 6'd1);
        send_request(lcdseq_pkg::OP_CURSOR, 8'hFF, 2'd1, 6'd40);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd2, 6'd1);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd2, 6'd40);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd0, 6'd5);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd3, 6'd63);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd1, 6'd0);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd2, 6'd0);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd1, 6'd63);

        // zero settle times and a pulse of 1 us
        write_settings(16'd1, 16'd0, 16'd0);
        send_request(lcdseq_pkg::OP_INIT, 8'h00, 2'd0, 6'd0);
        send_request(lcdseq_pkg::OP_CMD, 8'hA5, 2'd0, 6'd0);
        send_request(lcdseq_pkg::OP_DATA, 8'h3C, 2'd0, 6'd0);

        // all-ones writes, pulse keeps only its low bits
        write_settings(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(lcdseq_pkg::OP_INIT, 8'h00, 2'd0, 6'd0);
        send_request(lcdseq_pkg::OP_CMD, 8'h5A, 2'd0, 6'd0);
        send_request(lcdseq_pkg::OP_DATA, 8'hC3, 2'd0, 6'd0);
        send_request(lcdseq_pkg::OP_CURSOR, 8'h00, 2'd2, 6'd17);

        // random segments under different settings
        write_settings(16'd1000, 16'($urandom), 16'($urandom));
        random_requests(SEGMENT_ITEMS);

        write_settings(16'($urandom), 16'($urandom), 16'($urandom));
        quiet = 1'b1;
        random_requests(SEGMENT_ITEMS);
        quiet = 1'b0;

        write_settings(16'd0, 16'd1, 16'd65534);
        hold_off_req = 1'b1;
        random_requests(SEGMENT_ITEMS);

        write_settings(16'($urandom_range(1, 1000)), 16'($urandom), 16'($urandom));
        random_requests(SEGMENT_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending == 0) begin
            $display("char_lcd_nibble_bus_sequencer: match");
        end else begin
            $display("char_lcd_nibble_bus_sequencer: mismatch");
        end
        $finish;
    end

    // phase sink: random back-pressure, one long hold-off on demand
    initial begin
        phase_if.ready <= 1'b0;
        hold_off_done  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req && !hold_off_done) begin
                phase_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                phase_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) ||
            (phase_if.valid && phase_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("char_lcd_nibble_bus_sequencer: mismatch");
            $finish;
        end
    end

endmodule
